@@ src/cfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame parser package
// Byte codes shared by the parser logic.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_NL    = 8'h0A;  // newline
  localparam logic [7:0] CH_BSL   = 8'h5C;  // backslash
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
  localparam logic [7:0] CH_TWO   = 8'h32;  // '2'
  localparam logic [7:0] CH_THREE = 8'h33;  // '3'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned STATE_W = 3;

endpackage

@@ src/cfp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame parser channels
// Valid/ready channels for received bytes and for parse results.
// ----------------------------------------------------------------------------
interface cfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfp_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [3:0] data_index;
  logic       frame_done;
  logic [7:0] cmd_code;
  logic [3:0] data_count;
  logic       framing_error;
  logic [2:0] parser_state;

  modport source (
    output valid, output data_valid, output data_byte, output data_index,
    output frame_done, output cmd_code, output data_count,
    output framing_error, output parser_state, input ready
  );
  modport sink (
    input valid, input data_valid, input data_byte, input data_index,
    input frame_done, input cmd_code, input data_count,
    input framing_error, input parser_state, output ready
  );
endinterface

@@ src/command_frame_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame parser
// Parses '#', size digit, command letter, payload with escapes, newline.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one received byte per request (rx_byte).
//   out_ch : one result per accepted byte: decoded payload byte with its
//            index, frame-done pulse with command and length, framing error
//            flag and the parser state after the byte.
//   Each byte is decoded by the state machine in the cycle it is accepted;
//   the result sits in the output register from the next cycle, and one byte is
//   taken every cycle while results drain.
//   A stalled receiver holds the output register; in_ch.ready drops only
//   while a result waits and out_ch.ready is low, so no result is lost.
//   Reset puts the parser in the expect-hash state with counters and the
//   command letter cleared and the output register empty.
//   A corrupt stream is recovered only by a '#', which starts a new frame.
// ----------------------------------------------------------------------------
module command_frame_parser
  import cfp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  cfp_in_if.sink           in_ch,
  cfp_out_if.source        out_ch
);

  typedef enum logic [STATE_W-1:0] {
    ST_CORRUPT = 3'd0,
    ST_HASH    = 3'd1,
    ST_SIZE    = 3'd2,
    ST_CMD     = 3'd3,
    ST_DATA    = 3'd4,
    ST_ESC     = 3'd5,
    ST_END     = 3'd6
  } state_t;

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   exp_cnt_r, exp_cnt_nxt;
  logic [COUNT_W-1:0]   rcv_cnt_r, rcv_cnt_nxt;
  logic [BYTE_W-1:0]    cmd_r, cmd_nxt;

  logic                 out_valid_r;
  logic                 dvalid_r, dvalid_nxt;
  logic [BYTE_W-1:0]    dbyte_r, dbyte_nxt;
  logic [COUNT_W-1:0]   dindex_r, dindex_nxt;
  logic                 done_r, done_nxt;
  logic [BYTE_W-1:0]    cmd_out_r, cmd_out_nxt;
  logic [COUNT_W-1:0]   count_out_r, count_out_nxt;
  logic                 err_r, err_nxt;

  logic [BYTE_W-1:0]    c;
  logic                 accept;
  logic                 store;
  logic                 good_prev;
  logic [COUNT_W-1:0]   rcv_inc;

  assign c         = in_ch.rx_byte;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept    = in_ch.valid && in_ch.ready;
  assign rcv_inc   = rcv_cnt_r + COUNT_W'(1);

  always_comb begin
    state_nxt     = ST_CORRUPT;
    exp_cnt_nxt   = exp_cnt_r;
    rcv_cnt_nxt   = rcv_cnt_r;
    cmd_nxt       = cmd_r;
    store         = 1'b0;
    dbyte_nxt     = '0;
    done_nxt      = 1'b0;
    cmd_out_nxt   = '0;
    count_out_nxt = '0;
    good_prev     = 1'b1;

    case (state_r)
      ST_HASH: begin
        if (c == CH_HASH) state_nxt = ST_SIZE;
      end
      ST_SIZE: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          exp_cnt_nxt = COUNT_W'(c - CH_ZERO);
          state_nxt   = ST_CMD;
        end
      end
      ST_CMD: begin
        if ((c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z)) begin
          cmd_nxt = c;
          if (exp_cnt_r != '0) begin
            rcv_cnt_nxt = '0;
            state_nxt   = ST_DATA;
          end else begin
            state_nxt = ST_END;
          end
        end
      end
      ST_DATA: begin
        if (c == CH_BSL) begin
          state_nxt = ST_ESC;
        end else begin
          dbyte_nxt = c;
          store     = 1'b1;
        end
      end
      ST_ESC: begin
        case (c)
          CH_ZERO:  begin dbyte_nxt = 8'h00;  store = 1'b1; end
          CH_ONE:   begin dbyte_nxt = CH_HASH; store = 1'b1; end
          CH_TWO:   begin dbyte_nxt = CH_NL;  store = 1'b1; end
          CH_THREE: begin dbyte_nxt = CH_BSL; store = 1'b1; end
          default:  ;
        endcase
      end
      ST_END: begin
        if (c == CH_NL) begin
          done_nxt      = 1'b1;
          cmd_out_nxt   = cmd_r;
          count_out_nxt = exp_cnt_r;
          state_nxt     = ST_HASH;
        end
      end
      default: begin
        // corrupt, and the unused code behaves the same
        good_prev = 1'b0;
        if (c == CH_HASH) state_nxt = ST_SIZE;
      end
    endcase

    dvalid_nxt = store;
    dindex_nxt = store ? rcv_cnt_r : '0;
    if (store) begin
      rcv_cnt_nxt = rcv_inc;
      state_nxt   = (rcv_inc == exp_cnt_r) ? ST_END : ST_DATA;
    end

    err_nxt = good_prev && (state_nxt == ST_CORRUPT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HASH;
      exp_cnt_r   <= '0;
      rcv_cnt_r   <= '0;
      cmd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        exp_cnt_r   <= exp_cnt_nxt;
        rcv_cnt_r   <= rcv_cnt_nxt;
        cmd_r       <= cmd_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted byte
  always_ff @(posedge clk) begin
    if (accept) begin
      dvalid_r    <= dvalid_nxt;
      dbyte_r     <= dbyte_nxt;
      dindex_r    <= dindex_nxt;
      done_r      <= done_nxt;
      cmd_out_r   <= cmd_out_nxt;
      count_out_r <= count_out_nxt;
      err_r       <= err_nxt;
    end
  end

  logic [STATE_W-1:0] state_out_r;

  always_ff @(posedge clk) begin
    if (accept) state_out_r <= state_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.data_valid    = dvalid_r;
  assign out_ch.data_byte     = dbyte_r;
  assign out_ch.data_index    = dindex_r;
  assign out_ch.frame_done    = done_r;
  assign out_ch.cmd_code      = cmd_out_r;
  assign out_ch.data_count    = count_out_r;
  assign out_ch.framing_error = err_r;
  assign out_ch.parser_state  = state_out_r;

endmodule
